>>> rtl/tcw_pkg.sv
// Shared types and constants of the text console writer.
// Holds screen geometry, operation and control-byte codes, and the structs
// passed between the sequencer, the screen memory and the top level.
`default_nettype none

package tcw_pkg;

   // Screen geometry
   localparam int COLS   = 80;
   localparam int ROWS   = 25;
   localparam int CELLS  = ROWS * COLS;

   // Internal widths
   localparam int ADDR_W = $clog2(CELLS);
   localparam int CNT_W  = $clog2(CELLS + 1);
   localparam int RW     = $clog2(ROWS);
   localparam int CW     = $clog2(COLS);
   localparam int CELL_W = 16;

   // Port field widths
   localparam int OP_W        = 3;
   localparam int BYTE_W      = 8;
   localparam int ROW_FIELD_W = 6;
   localparam int COL_FIELD_W = 8;
   localparam int INDEX_W     = 15;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 8;

   // Operation codes
   localparam logic [OP_W-1:0] OP_PUT   = 3'd0;
   localparam logic [OP_W-1:0] OP_SET   = 3'd1;
   localparam logic [OP_W-1:0] OP_DRAW  = 3'd2;
   localparam logic [OP_W-1:0] OP_READ  = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR = 3'd4;

   // Control bytes and the blank character
   localparam logic [BYTE_W-1:0] CH_NEWLINE   = 8'd10;
   localparam logic [BYTE_W-1:0] CH_RETURN    = 8'd13;
   localparam logic [BYTE_W-1:0] CH_BACKSPACE = 8'd8;
   localparam logic [BYTE_W-1:0] BLANK_CHAR   = 8'h20;

   // Register indexes and reset values
   localparam logic [CSR_IDX_W-1:0] CSR_TEXT_COLOR    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_CURSOR_OFF    = 1'b1;
   localparam logic [BYTE_W-1:0]    TEXT_COLOR_RESET  = 8'h07;

   // Cursor index reported while hidden
   localparam logic [INDEX_W-1:0] HIDDEN_INDEX = INDEX_W'(CELLS + 1);

   typedef struct packed {
      logic [OP_W-1:0]        operation;
      logic [BYTE_W-1:0]      byte_value;
      logic [ROW_FIELD_W-1:0] row;
      logic [COL_FIELD_W-1:0] column;
      logic [BYTE_W-1:0]      cell_color;
   } req_type;

   typedef struct packed {
      logic                   status;
      logic [BYTE_W-1:0]      read_char;
      logic [BYTE_W-1:0]      read_attr;
      logic [ROW_FIELD_W-1:0] cursor_row_now;
      logic [COL_FIELD_W-1:0] cursor_col_now;
      logic [INDEX_W-1:0]     cursor_index;
   } rsp_type;

   typedef struct packed {
      logic [BYTE_W-1:0] text_color;
      logic              cursor_off;
   } cfg_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [CELL_W-1:0] wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } ram_req_type;

endpackage

`default_nettype wire

>>> rtl/tcw_if.sv
// Channel interfaces of the text console writer: request, response and
// register write. Depends on tcw_pkg for field widths.
`default_nettype none

interface tcw_req_if;
   import tcw_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [OP_W-1:0]        operation;
   logic [BYTE_W-1:0]      byte_value;
   logic [ROW_FIELD_W-1:0] row;
   logic [COL_FIELD_W-1:0] column;
   logic [BYTE_W-1:0]      cell_color;
   modport source (output valid, operation, byte_value, row, column, cell_color,
                   input ready);
   modport sink   (input valid, operation, byte_value, row, column, cell_color,
                   output ready);
endinterface

interface tcw_rsp_if;
   import tcw_pkg::*;
   logic                   valid;
   logic                   ready;
   logic                   status;
   logic [BYTE_W-1:0]      read_char;
   logic [BYTE_W-1:0]      read_attr;
   logic [ROW_FIELD_W-1:0] cursor_row_now;
   logic [COL_FIELD_W-1:0] cursor_col_now;
   logic [INDEX_W-1:0]     cursor_index;
   modport source (output valid, status, read_char, read_attr, cursor_row_now,
                   cursor_col_now, cursor_index, input ready);
   modport sink   (input valid, status, read_char, read_attr, cursor_row_now,
                   cursor_col_now, cursor_index, output ready);
endinterface

interface tcw_csr_if;
   import tcw_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/tcw_screen_ram.sv
// Screen cell store: one write port and one read port, registered read data.
// Depends on tcw_pkg for depth, address width and the request struct.
`default_nettype none

module tcw_screen_ram import tcw_pkg::*; (
   input  wire logic              clock,
   input  wire ram_req_type       ram_req,
   output logic [CELL_W-1:0]      rd_data
);

   logic [CELL_W-1:0] screen_mem [CELLS];

   // Write port
   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         screen_mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
   end

   // Read port, registered read data
   always_ff @(posedge clock) begin
      if (ram_req.rd_en) begin
         rd_data <= screen_mem[ram_req.rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> rtl/tcw_engine.sv
// Command sequencer of the text console writer: decodes one request, moves
// the cursor and drives the screen memory, including scroll and clear sweeps.
// Depends on tcw_pkg.
`default_nettype none

module tcw_engine import tcw_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req,
   input  wire cfg_type     cfg,
   output ram_req_type      ram_req,
   input  wire logic [CELL_W-1:0] ram_rd_data,
   output logic             res_valid,
   input  wire logic        res_ready,
   output rsp_type          res
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_EXEC   = 3'd1;
   localparam logic [2:0] ST_RDWAIT = 3'd2;
   localparam logic [2:0] ST_SCROLL = 3'd3;
   localparam logic [2:0] ST_FILL   = 3'd4;
   localparam logic [2:0] ST_CLEAR  = 3'd5;
   localparam logic [2:0] ST_RESULT = 3'd6;

   localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(COLS);
   localparam logic [INDEX_W-1:0] COLS_I   = INDEX_W'(COLS);
   localparam logic [RW-1:0]     LAST_ROW  = RW'(ROWS - 1);
   localparam logic [CW-1:0]     LAST_COL  = CW'(COLS - 1);
   localparam logic [CNT_W-1:0]  CNT_END   = CNT_W'(CELLS);
   localparam logic [CNT_W-1:0]  CNT_LAST  = CNT_W'(CELLS - 1);
   localparam logic [CNT_W-1:0]  CNT_COLS  = CNT_W'(COLS);
   localparam logic [CNT_W-1:0]  CNT_FILL  = CNT_W'(CELLS - COLS);

   logic [2:0]              state_ff, state_in;
   req_type                 cmd_ff, cmd_in;
   logic [RW-1:0]           cur_row_ff, cur_row_in;
   logic [CW-1:0]           cur_col_ff, cur_col_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    copy_vld_ff, copy_vld_in;
   logic [ADDR_W-1:0]       copy_dst_ff, copy_dst_in;
   logic                    status_ff, status_in;
   logic [BYTE_W-1:0]       rchar_ff, rchar_in;
   logic [BYTE_W-1:0]       rattr_ff, rattr_in;

   logic [ADDR_W-1:0]       pos_addr;
   logic [ADDR_W-1:0]       tgt_addr;
   logic                    in_range;
   logic [CELL_W-1:0]       blank_cell;
   logic                    last_row;
   logic                    last_col;

   // Address and range decode
   assign pos_addr   = ADDR_W'(cur_row_ff) * COLS_A + ADDR_W'(cur_col_ff);
   assign tgt_addr   = ADDR_W'(cmd_ff.row) * COLS_A + ADDR_W'(cmd_ff.column);
   assign in_range   = (32'(cmd_ff.row) < ROWS) && (32'(cmd_ff.column) < COLS);
   assign blank_cell = {cfg.text_color, BLANK_CHAR};
   assign last_row   = (cur_row_ff == LAST_ROW);
   assign last_col   = (cur_col_ff == LAST_COL);

   assign req_ready  = (state_ff == ST_IDLE);
   assign res_valid  = (state_ff == ST_RESULT);

   // Result fields
   always_comb begin
      res.status         = status_ff;
      res.read_char      = rchar_ff;
      res.read_attr      = rattr_ff;
      res.cursor_row_now = ROW_FIELD_W'(cur_row_ff);
      res.cursor_col_now = COL_FIELD_W'(cur_col_ff);
      res.cursor_index   = cfg.cursor_off ? HIDDEN_INDEX :
                           INDEX_W'(INDEX_W'(cur_row_ff) * COLS_I + INDEX_W'(cur_col_ff));
   end

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      cur_row_in  = cur_row_ff;
      cur_col_in  = cur_col_ff;
      cnt_in      = cnt_ff;
      copy_vld_in = 1'b0;
      copy_dst_in = copy_dst_ff;
      status_in   = status_ff;
      rchar_in    = rchar_ff;
      rattr_in    = rattr_ff;
      ram_req     = '0;

      unique case (state_ff) inside
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in   = req;
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            status_in = 1'b0;
            rchar_in  = '0;
            rattr_in  = '0;
            state_in  = ST_RESULT;
            case (cmd_ff.operation)
               OP_PUT: begin
                  if (cmd_ff.byte_value == CH_NEWLINE) begin
                     cur_col_in = '0;
                     if (last_row) begin
                        cnt_in   = CNT_COLS;
                        state_in = ST_SCROLL;
                     end else begin
                        cur_row_in = cur_row_ff + 1'b1;
                     end
                  end else if (cmd_ff.byte_value == CH_RETURN) begin
                     cur_col_in = '0;
                  end else if (cmd_ff.byte_value == CH_BACKSPACE) begin
                     // step back one cell, stopping at the first one
                     ram_req.wr_en   = 1'b1;
                     ram_req.wr_data = blank_cell;
                     ram_req.wr_addr = (pos_addr == '0) ? '0 : pos_addr - 1'b1;
                     if (cur_col_ff != '0) begin
                        cur_col_in = cur_col_ff - 1'b1;
                     end else if (cur_row_ff != '0) begin
                        cur_row_in = cur_row_ff - 1'b1;
                        cur_col_in = LAST_COL;
                     end
                  end else begin
                     ram_req.wr_en   = 1'b1;
                     ram_req.wr_addr = pos_addr;
                     ram_req.wr_data = {cfg.text_color, cmd_ff.byte_value};
                     if (last_col) begin
                        cur_col_in = '0;
                        if (last_row) begin
                           cnt_in   = CNT_COLS;
                           state_in = ST_SCROLL;
                        end else begin
                           cur_row_in = cur_row_ff + 1'b1;
                        end
                     end else begin
                        cur_col_in = cur_col_ff + 1'b1;
                     end
                  end
               end
               OP_SET: begin
                  if (in_range) begin
                     cur_row_in = RW'(cmd_ff.row);
                     cur_col_in = CW'(cmd_ff.column);
                  end else begin
                     status_in = 1'b1;
                  end
               end
               OP_DRAW: begin
                  if (in_range) begin
                     ram_req.wr_en   = 1'b1;
                     ram_req.wr_addr = tgt_addr;
                     ram_req.wr_data = {cmd_ff.cell_color, cmd_ff.byte_value};
                  end else begin
                     status_in = 1'b1;
                  end
               end
               OP_READ: begin
                  if (in_range) begin
                     ram_req.rd_en   = 1'b1;
                     ram_req.rd_addr = tgt_addr;
                     state_in        = ST_RDWAIT;
                  end else begin
                     status_in = 1'b1;
                  end
               end
               OP_CLEAR: begin
                  cur_row_in = '0;
                  cur_col_in = '0;
                  cnt_in     = '0;
                  state_in   = ST_CLEAR;
               end
               default: begin
                  status_in = 1'b1;
               end
            endcase
         end

         ST_RDWAIT: begin
            rchar_in = ram_rd_data[BYTE_W-1:0];
            rattr_in = ram_rd_data[CELL_W-1:BYTE_W];
            state_in = ST_RESULT;
         end

         ST_SCROLL: begin
            // write back the cell read last cycle one row higher
            if (copy_vld_ff) begin
               ram_req.wr_en   = 1'b1;
               ram_req.wr_addr = copy_dst_ff;
               ram_req.wr_data = ram_rd_data;
            end
            if (cnt_ff != CNT_END) begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = cnt_ff[ADDR_W-1:0];
               copy_vld_in     = 1'b1;
               copy_dst_in     = cnt_ff[ADDR_W-1:0] - COLS_A;
               cnt_in          = cnt_ff + 1'b1;
            end else begin
               cnt_in   = CNT_FILL;
               state_in = ST_FILL;
            end
         end

         ST_FILL, ST_CLEAR: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = cnt_ff[ADDR_W-1:0];
            ram_req.wr_data = blank_cell;
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_RESULT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         ST_RESULT: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         cur_row_ff  <= '0;
         cur_col_ff  <= '0;
         copy_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cur_row_ff  <= cur_row_in;
         cur_col_ff  <= cur_col_in;
         copy_vld_ff <= copy_vld_in;
      end
   end

   // Payload and sweep registers
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      cnt_ff      <= cnt_in;
      copy_dst_ff <= copy_dst_in;
      status_ff   <= status_in;
      rchar_ff    <= rchar_in;
      rattr_ff    <= rattr_in;
   end

endmodule

`default_nettype wire

>>> rtl/text_console_writer.sv
// Text console writer: 80x25 character/attribute screen with a cursor.
//
// Channels: req_chan takes one command beat (put byte, set cursor, draw
// cell, read cell, clear screen); rsp_chan returns exactly one beat per
// command with status, read cell data and the cursor after the command.
// csr_chan writes text_color (index 0) and cursor_off (index 1); it is
// always ready and is meant to be used while no command is in flight.
//
// Sequencing: a command runs in the execute state, and its response passes
// the sequencer's result state and the output register; a read cell also
// waits for the registered memory read. Only one command is taken at a time.
// A scroll (newline or wrap past the bottom row) copies each cell below the
// top row one row up over one read and one write port, then fills the bottom
// row with blanks. Clear screen writes a blank to every cell.
//
// Reset clears the cursor and loads the register defaults; screen contents
// stay undefined until written or cleared, and no clearing pass runs.
// Stall: the response sits in an output register until taken; one more
// command is accepted and processed meanwhile, then the sequencer holds.
// Depends on tcw_pkg, tcw_if, tcw_screen_ram and tcw_engine.
`default_nettype none

module text_console_writer import tcw_pkg::*; (
   input wire logic  clock,
   input wire logic  reset,
   tcw_req_if.sink   req_chan,
   tcw_rsp_if.source rsp_chan,
   tcw_csr_if.sink   csr_chan
);

   cfg_type           cfg_ff;
   req_type           req_beat;
   logic              eng_ready;
   ram_req_type       ram_req;
   logic [CELL_W-1:0] ram_rd_data;
   logic              res_valid;
   logic              res_ready;
   rsp_type           res;
   logic              out_valid_ff, out_valid_in;
   rsp_type           out_ff;

   // Gather the request beat
   always_comb begin
      req_beat.operation  = req_chan.operation;
      req_beat.byte_value = req_chan.byte_value;
      req_beat.row        = req_chan.row;
      req_beat.column     = req_chan.column;
      req_beat.cell_color = req_chan.cell_color;
   end
   assign req_chan.ready = eng_ready;

   // Configuration registers
   assign csr_chan.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.text_color <= TEXT_COLOR_RESET;
         cfg_ff.cursor_off <= 1'b0;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_TEXT_COLOR: cfg_ff.text_color <= csr_chan.data;
            CSR_CURSOR_OFF: cfg_ff.cursor_off <= csr_chan.data[0];
         endcase
      end
   end

   tcw_screen_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (ram_rd_data)
   );

   tcw_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_ready   (eng_ready),
      .req         (req_beat),
      .cfg         (cfg_ff),
      .ram_req     (ram_req),
      .ram_rd_data (ram_rd_data),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res)
   );

   // Output register: load when empty or being drained
   assign res_ready = !out_valid_ff || rsp_chan.ready;
   always_comb begin
      out_valid_in = out_valid_ff;
      if (res_ready) begin
         out_valid_in = res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_ready && res_valid) begin
         out_ff <= res;
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.status         = out_ff.status;
   assign rsp_chan.read_char      = out_ff.read_char;
   assign rsp_chan.read_attr      = out_ff.read_attr;
   assign rsp_chan.cursor_row_now = out_ff.cursor_row_now;
   assign rsp_chan.cursor_col_now = out_ff.cursor_col_now;
   assign rsp_chan.cursor_index   = out_ff.cursor_index;

endmodule

`default_nettype wire
